// ----- sv/fcw_pkg.sv -----
// Package for the front-coded word list decoder.
// Holds the controller state type, the command and status structs and
// the fixed field constants. Depends on nothing.
package fcw_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned NUM_W  = 16;

  // Bit 7 of a character byte marks the last character of a word.
  localparam int unsigned END_BIT = 7;

  // Controller states: one per part of an entry, plus word emission.
  typedef enum logic [2:0] {
    ST_PREFIX,
    ST_CHARS,
    ST_NUM_HI,
    ST_NUM_LO,
    ST_EMIT
  } fcw_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_prefix;
    logic take_char;
    logic take_hi;
    logic take_lo;
    logic emit;
    logic clear_ovf;
  } fcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic char_end;
    logic emit_done;
  } fcw_stat_t;

endpackage

// ----- sv/fcw_if.sv -----
// Channel interfaces of the front-coded word list decoder.
// fcw_in_if carries input bytes, fcw_out_if carries decoded characters.
// Depends on nothing.
interface fcw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface fcw_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  character;
  logic [5:0]  char_position;
  logic [15:0] word_number;
  logic        last_char;
  logic        overflow;

  modport source (
    output valid, output character, output char_position,
    output word_number, output last_char, output overflow, input ready
  );
  modport sink (
    input valid, input character, input char_position,
    input word_number, input last_char, input overflow, output ready
  );
endinterface

// ----- sv/fcw_ctrl.sv -----
// Controller of the front-coded word list decoder.
// Walks through the parts of each entry and sequences word emission.
// Depends on fcw_pkg.
module fcw_ctrl
  import fcw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fcw_stat_t stat,
  output fcw_cmd_t  cmd
);

  fcw_state_t state_r;
  fcw_state_t state_nxt;
  logic       take;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PREFIX;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Input bytes are taken in every state but emission.
  assign in_ready = (state_r != ST_EMIT);
  assign take     = in_valid && in_ready;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_PREFIX: begin
        cmd.take_prefix = take;
        if (take) state_nxt = ST_CHARS;
      end
      ST_CHARS: begin
        cmd.take_char = take;
        if (take && stat.char_end) state_nxt = ST_NUM_HI;
      end
      ST_NUM_HI: begin
        cmd.take_hi = take;
        if (take) state_nxt = ST_NUM_LO;
      end
      ST_NUM_LO: begin
        cmd.take_lo = take;
        if (take) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.emit_done) begin
          cmd.clear_ovf = 1'b1;
          state_nxt     = ST_PREFIX;
        end
      end
      default: begin
        state_nxt = ST_PREFIX;
      end
    endcase
  end

endmodule

// ----- sv/fcw_dp.sv -----
// Datapath of the front-coded word list decoder.
// Holds the word buffer memory, length, number and the output register.
// Depends on fcw_pkg and fcw_out_if.
module fcw_dp
  import fcw_pkg::*;
#(
  parameter int unsigned MAX_WORD = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] data_byte,
  input  fcw_cmd_t          cmd,
  output fcw_stat_t         stat,
  fcw_out_if.source         out_ch
);

  localparam int unsigned LW = $clog2(MAX_WORD + 1);
  localparam int unsigned AW = $clog2(MAX_WORD);

  // Word buffer; an entry never written reads as zero.
  logic [CHAR_W-1:0]   mem [MAX_WORD];
  logic [MAX_WORD-1:0] vld_r;

  logic [LW-1:0]     len_r;
  logic              ovf_r;
  logic [BYTE_W-1:0] hi_r;
  logic [NUM_W-1:0]  num_r;

  // Emission read pipeline.
  logic [LW-1:0]     rd_idx_r;
  logic              rv_r;
  logic [CHAR_W-1:0] q_char_r;
  logic              q_vld_r;
  logic [LW-1:0]     q_idx_r;
  logic [LW:0]       q_next;

  // Output register.
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [NUM_W-1:0]  out_num_r;
  logic              out_last_r;
  logic              out_ovf_r;

  logic prefix_big;
  logic in_range;
  logic load_out;
  logic issue;

  assign prefix_big = {1'b0, data_byte} > (BYTE_W + 1)'(MAX_WORD);
  assign in_range   = len_r < LW'(MAX_WORD);
  assign load_out   = rv_r && (!out_valid_r || out_ch.ready);
  assign issue      = cmd.emit && (rd_idx_r != len_r) && (!rv_r || load_out);
  assign q_next     = {1'b0, q_idx_r} + (LW + 1)'(1);

  assign stat.char_end  = data_byte[END_BIT];
  assign stat.emit_done = (rd_idx_r == len_r) && !rv_r;

  // Word length, overflow flag and word number.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
      hi_r  <= '0;
    end else begin
      if (cmd.take_prefix) begin
        if (prefix_big) begin
          len_r <= LW'(MAX_WORD);
          ovf_r <= 1'b1;
        end else begin
          len_r <= LW'(data_byte);
        end
      end else if (cmd.take_char) begin
        if (in_range) begin
          len_r <= len_r + LW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end else if (cmd.take_hi) begin
        hi_r <= data_byte;
      end else if (cmd.clear_ovf) begin
        ovf_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_lo) begin
      num_r <= {hi_r, data_byte};
    end
  end

  // Valid bits of the word buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.take_char && in_range) begin
      vld_r[len_r[AW-1:0]] <= 1'b1;
    end
  end

  // Buffer write of a decoded character, and registered read for emission.
  always_ff @(posedge clk) begin
    if (cmd.take_char && in_range) begin
      mem[len_r[AW-1:0]] <= ~data_byte[CHAR_W-1:0];
    end
    if (issue) begin
      q_char_r <= mem[rd_idx_r[AW-1:0]];
      q_vld_r  <= vld_r[rd_idx_r[AW-1:0]];
      q_idx_r  <= rd_idx_r;
    end
  end

  // Read index and read-data valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      rv_r     <= 1'b0;
    end else begin
      if (cmd.take_lo) begin
        rd_idx_r <= '0;
      end else if (issue) begin
        rd_idx_r <= rd_idx_r + LW'(1);
      end
      if (issue) begin
        rv_r <= 1'b1;
      end else if (load_out) begin
        rv_r <= 1'b0;
      end
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char_r <= q_vld_r ? q_char_r : '0;
      out_pos_r  <= POS_W'(q_idx_r);
      out_num_r  <= num_r;
      out_last_r <= (q_next == {1'b0, len_r});
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.character     = out_char_r;
  assign out_ch.char_position = out_pos_r;
  assign out_ch.word_number   = out_num_r;
  assign out_ch.last_char     = out_last_r;
  assign out_ch.overflow      = out_ovf_r;

endmodule

// ----- sv/front_coded_word_list_decoder.sv -----
// Front-coded word list decoder, top level.
// The input channel in_ch takes one data byte per transaction: a shared
// prefix count, then characters with their low 7 bits inverted and bit 7
// set on the last one, then a big-endian 16-bit word number.
// After the low number byte, the rebuilt word leaves on out_ch, one
// character per transaction, with its position, the word number, a
// last-character flag and an overflow flag for clamped lengths.
// Emission starts once the low number byte is taken; the buffer then
// yields one character per cycle while out_ch does not stall, set by
// its single read port, each passing a read register and then the
// output register. in_ch is held off during emission and reopens after
// the last character moves to the output register and emission ends.
// A stall on out_ch holds the output register and pauses emission.
// Reset (rst_n low, synchronous) returns to expecting a prefix count and
// makes the whole word buffer read as zeros.
// Depends on fcw_pkg, fcw_if, fcw_ctrl and fcw_dp.
module front_coded_word_list_decoder
  import fcw_pkg::*;
#(
  parameter int unsigned MAX_WORD = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  fcw_in_if.sink    in_ch,
  fcw_out_if.source out_ch
);

  fcw_cmd_t  cmd;
  fcw_stat_t stat;

  // Entry sequencing.
  fcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Buffer, number and result register.
  fcw_dp #(
    .MAX_WORD (MAX_WORD)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .data_byte (in_ch.data_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_ch    (out_ch)
  );

endmodule
